### rtl/mstt_pkg.sv
// Shared types, codes and helpers of the multi-slot timer table.
package mstt_pkg;

    localparam int OP_W   = 2;
    localparam int NOW_W  = 32;
    localparam int PER_W  = 20;
    localparam int RUNS_W = 17;
    localparam int KIND_W = 2;
    localparam int SLOT_W = 4;

    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_ONCE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD_REPEAT = 2'd2;

    localparam logic signed [RUNS_W-1:0] RUNS_ENDLESS = -17'sd1;
    localparam logic signed [RUNS_W-1:0] RUNS_NONE    = 17'sd0;
    localparam logic signed [RUNS_W-1:0] RUNS_ONE     = 17'sd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    // Command latched at acceptance and broadcast to every cell.
    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [NOW_W-1:0]         now_seconds;
        logic [PER_W-1:0]         period_seconds;
        logic signed [RUNS_W-1:0] repeat_count;
    } cmd_t;

    // Control from the sequencer to every cell.
    typedef struct packed {
        logic shift;
        logic purge;
    } cell_ctl_t;

    // Status from one cell back to the sequencer.
    typedef struct packed {
        logic busy;
        logic fire;
        logic claim;
        logic purge_req;
    } cell_rsp_t;

    // Time plus delay, clamped at the largest representable time.
    function automatic logic [NOW_W-1:0] sat_add(input logic [NOW_W-1:0] a,
                                                 input logic [PER_W-1:0] b);
        logic [NOW_W:0] s;
        s = (NOW_W+1)'(a) + (NOW_W+1)'(b);
        return s[NOW_W] ? {NOW_W{1'b1}} : s[NOW_W-1:0];
    endfunction

endpackage

### rtl/mstt_in_if.sv
// Input channel of the timer table: handshake plus command fields.
interface mstt_in_if;
    import mstt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [NOW_W-1:0]         now_seconds;
    logic [PER_W-1:0]         period_seconds;
    logic signed [RUNS_W-1:0] repeat_count;

    modport source (output valid, opcode, now_seconds, period_seconds, repeat_count,
                    input ready);
    modport sink (input valid, opcode, now_seconds, period_seconds, repeat_count,
                  output ready);
endinterface

### rtl/mstt_out_if.sv
// Output channel of the timer table: handshake plus result fields.
interface mstt_out_if;
    import mstt_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              last;

    modport source (output valid, kind, slot, last, input ready);
    modport sink (input valid, kind, slot, last, output ready);
endinterface

### rtl/mstt_cell.sv
// One timer slot of the chain: holds its timer and acts when the scan token reaches it.
module mstt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mstt_pkg::cmd_t     cmd,
    input  mstt_pkg::cell_ctl_t ctl,
    input  logic               tok_in,
    output logic               tok_out,
    output mstt_pkg::cell_rsp_t rsp
);
    import mstt_pkg::*;

    logic                     valid_reg, valid_next;
    logic                     tok_reg, tok_next;
    logic [NOW_W-1:0]         due_reg;
    logic                     once_reg;
    logic signed [RUNS_W-1:0] runs_reg;
    logic [PER_W-1:0]         intv_reg;

    logic             is_tick, is_add, is_due, active, can_run;
    logic             fire, claim, purge_req, rearm, free_now;
    logic [NOW_W-1:0] resched;

    always_comb
    begin
        is_tick   = (cmd.opcode == OP_TICK);
        is_add    = cmd.opcode inside {OP_ADD_ONCE, OP_ADD_REPEAT};
        is_due    = valid_reg && (cmd.now_seconds >= due_reg);
        active    = tok_reg && ctl.shift;
        can_run   = once_reg || (runs_reg > RUNS_NONE) || (runs_reg == RUNS_ENDLESS);
        resched   = sat_add(cmd.now_seconds, intv_reg);
        fire      = active && is_tick && is_due && can_run;
        purge_req = active && is_tick && is_due && (once_reg || !can_run);
        claim     = active && is_add && !valid_reg;
        rearm     = fire && !once_reg;
        // Purge frees one-shots that are due and recurring slots that ran out.
        free_now  = ctl.purge && valid_reg &&
                    ((once_reg && is_due) || (!once_reg && runs_reg == RUNS_NONE));

        // A claiming cell swallows the token so the walk stops here.
        tok_out   = tok_reg && !(is_add && !valid_reg);
        tok_next  = ctl.shift ? tok_in : tok_reg;

        valid_next = valid_reg;
        if (claim)
        begin
            valid_next = 1'b1;
        end
        else if (free_now)
        begin
            valid_next = 1'b0;
        end

        rsp.busy      = tok_reg;
        rsp.fire      = fire;
        rsp.claim     = claim;
        rsp.purge_req = purge_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            if (cmd.opcode == OP_ADD_ONCE)
            begin
                due_reg  <= sat_add(cmd.now_seconds, cmd.period_seconds);
                once_reg <= 1'b1;
                runs_reg <= RUNS_ONE;
                intv_reg <= '0;
            end
            else
            begin
                due_reg  <= cmd.now_seconds;
                once_reg <= 1'b0;
                runs_reg <= cmd.repeat_count;
                intv_reg <= cmd.period_seconds;
            end
        end
        else if (rearm)
        begin
            due_reg <= resched;
            if (runs_reg > RUNS_NONE)
            begin
                runs_reg <= runs_reg - RUNS_ONE;
            end
        end
    end

endmodule

### rtl/multi_slot_software_timer_table.sv
// Top level of the multi-slot timer table: sequencer, result register and chain of slot cells.
// An add is accepted and then scans the slots in order until it claims a free slot or finds
// none; a tick walks every slot and then runs a finishing step.
// The scan token steps one cell per cycle while the result register can take an item; items are taken one at a time.
// Reset empties the table at once through the per-slot valid flags; no clearing pass runs.
module multi_slot_software_timer_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mstt_in_if.sink    req,
    mstt_out_if.source rsp
);
    import mstt_pkg::*;

    localparam int IDX_W = $clog2(TIMER_SLOTS);

    // One-hot sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              purge_reg, purge_next;

    // Result register that decouples the scan from the consumer.
    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              last_reg, last_next;

    logic              accept, start, advance, step, at_end;
    cell_ctl_t         ctl;
    cell_rsp_t         cell_rsp [TIMER_SLOTS];
    logic              tok_out [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] busy_vec;
    logic              any_fire, any_claim, any_purge;

    // The chain: the token enters cell 0 when an item starts and then moves
    // one cell per scan step, each cell handing it to its right neighbor.
    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                mstt_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .cmd     (cmd_reg),
                    .ctl     (ctl),
                    .tok_in  (start),
                    .tok_out (tok_out[g]),
                    .rsp     (cell_rsp[g])
                );
            end
            else
            begin : g_body
                mstt_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .cmd     (cmd_reg),
                    .ctl     (ctl),
                    .tok_in  (tok_out[g-1]),
                    .tok_out (tok_out[g]),
                    .rsp     (cell_rsp[g])
                );
            end
        end
    endgenerate

    // Only the cell holding the token can report, so a plain OR merges them.
    always_comb
    begin
        any_fire  = 1'b0;
        any_claim = 1'b0;
        any_purge = 1'b0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            busy_vec[i] = cell_rsp[i].busy;
            any_fire    = any_fire | cell_rsp[i].fire;
            any_claim   = any_claim | cell_rsp[i].claim;
            any_purge   = any_purge | cell_rsp[i].purge_req;
        end
    end

    always_comb
    begin
        // Items are taken only while no walk is running.
        req.ready = (state_reg == ST_IDLE);
        accept    = req.valid && req.ready;
        // The unused opcode is swallowed without any walk or result.
        start     = accept && (req.opcode inside {OP_TICK, OP_ADD_ONCE, OP_ADD_REPEAT});
        // A scan step may run whenever the result register can take a new item.
        advance   = !out_valid_reg || rsp.ready;
        step      = (state_reg == ST_SCAN) && advance;
        at_end    = (idx_reg == IDX_W'(TIMER_SLOTS - 1));

        ctl.shift = start || step;
        ctl.purge = (state_reg == ST_DONE) && advance && purge_reg;

        state_next     = state_reg;
        idx_next       = idx_reg;
        purge_next     = purge_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    purge_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    purge_next = purge_reg || any_purge;
                    if (any_claim)
                    begin
                        // The add found its slot; the walk ends here.
                        out_valid_next = 1'b1;
                        kind_next      = KIND_ADDED;
                        slot_next      = SLOT_W'(idx_reg);
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (any_fire)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_FIRED;
                        slot_next      = SLOT_W'(idx_reg);
                        last_next      = 1'b0;
                    end
                    if (at_end && !any_claim)
                    begin
                        if (cmd_reg.opcode == OP_TICK)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            // Every slot was taken.
                            out_valid_next = 1'b1;
                            kind_next      = KIND_FULL;
                            slot_next      = '0;
                            last_next      = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                // A requested purge pass runs in all cells at once with the finish result.
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_DONE;
                    slot_next      = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            purge_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            purge_reg     <= purge_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.opcode         <= req.opcode;
            cmd_reg.now_seconds    <= req.now_seconds;
            cmd_reg.period_seconds <= req.period_seconds;
            cmd_reg.repeat_count   <= req.repeat_count;
        end
        kind_reg <= kind_next;
        slot_reg <= slot_next;
        last_reg <= last_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.kind  = kind_reg;
    assign rsp.slot  = slot_reg;
    assign rsp.last  = last_reg;

`ifndef SYNTHESIS
    // The scan token is never duplicated along the chain.
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(busy_vec))
        else $error("more than one cell holds the scan token");

    // A new item starts only on an empty chain.
    a_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> (busy_vec == '0))
        else $error("item accepted while the token is still in the chain");

    // During a walk the token sits in the cell the scan index points at.
    a_token_tracks_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> busy_vec[idx_reg])
        else $error("scan token and scan index disagree");

    // The finishing step sees the token already off the end of the chain.
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (busy_vec == '0))
        else $error("token still in the chain at tick finish");

    // A cell never both claims and fires in the same step.
    a_claim_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !(any_claim && any_fire))
        else $error("claim and fire in the same scan step");
`endif

endmodule

### test/mstt_checker.sv
// Scoreboard of the timer table: mirrors the slot table and checks every result item.
module mstt_checker #(
    parameter int SLOTS = 16
) (
    input  logic clk,
    input  logic rst_n,
    mstt_in_if   cmd,
    mstt_out_if  evt,
    output int   fail_count,
    output int   pending_count
);
    import mstt_pkg::*;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } timer_event_t;

    // Shadow copy of the slot table.
    logic                     armed     [SLOTS];
    logic [NOW_W-1:0]         due_at    [SLOTS];
    logic                     one_shot  [SLOTS];
    logic signed [RUNS_W-1:0] runs_left [SLOTS];
    logic [PER_W-1:0]         every     [SLOTS];

    timer_event_t expected_events[$];

    function automatic logic [NOW_W-1:0] later(input logic [NOW_W-1:0] t,
                                               input logic [PER_W-1:0] d);
        logic [NOW_W:0] sum;
        sum = {1'b0, t} + {{(NOW_W + 1 - PER_W){1'b0}}, d};
        return sum[NOW_W] ? {NOW_W{1'b1}} : sum[NOW_W-1:0];
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10)
        begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        fail_count = fail_count + 1;
    endtask

    // Applies one accepted command to the shadow table and queues the events it causes.
    task automatic predict_command(input logic [OP_W-1:0] op,
                                   input logic [NOW_W-1:0] now,
                                   input logic [PER_W-1:0] per,
                                   input logic signed [RUNS_W-1:0] reps);
        int   i;
        int   free_idx;
        logic purge;
        logic fires;
        free_idx = -1;
        purge = 1'b0;
        if (op == OP_ADD_ONCE || op == OP_ADD_REPEAT)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (!armed[i] && free_idx < 0)
                begin
                    free_idx = i;
                end
            end
            if (free_idx < 0)
            begin
                expected_events.push_back('{KIND_FULL, '0, 1'b1});
            end
            else
            begin
                armed[free_idx] = 1'b1;
                if (op == OP_ADD_ONCE)
                begin
                    due_at[free_idx]    = later(now, per);
                    one_shot[free_idx]  = 1'b1;
                    runs_left[free_idx] = RUNS_ONE;
                    every[free_idx]     = '0;
                end
                else
                begin
                    due_at[free_idx]    = now;
                    one_shot[free_idx]  = 1'b0;
                    runs_left[free_idx] = reps;
                    every[free_idx]     = per;
                end
                expected_events.push_back('{KIND_ADDED, SLOT_W'(free_idx), 1'b1});
            end
        end
        else if (op == OP_TICK)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (armed[i] && now >= due_at[i])
                begin
                    fires = 1'b1;
                    if (one_shot[i])
                    begin
                        purge = 1'b1;
                    end
                    else if (runs_left[i] > RUNS_NONE)
                    begin
                        runs_left[i] = runs_left[i] - RUNS_ONE;
                    end
                    else if (runs_left[i] != RUNS_ENDLESS)
                    begin
                        // Exhausted or malformed count: no event, only a request to sweep.
                        purge = 1'b1;
                        fires = 1'b0;
                    end
                    if (fires && !one_shot[i])
                    begin
                        due_at[i] = later(now, every[i]);
                    end
                    if (fires)
                    begin
                        expected_events.push_back('{KIND_FIRED, SLOT_W'(i), 1'b0});
                    end
                end
            end
            if (purge)
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (armed[i] && ((one_shot[i] && now >= due_at[i]) ||
                                     (!one_shot[i] && runs_left[i] == RUNS_NONE)))
                    begin
                        armed[i] = 1'b0;
                    end
                end
            end
            expected_events.push_back('{KIND_DONE, '0, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        timer_event_t want;
        int           i;
        if (!rst_n)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                armed[i] = 1'b0;
            end
            expected_events.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                predict_command(cmd.opcode, cmd.now_seconds, cmd.period_seconds,
                                cmd.repeat_count);
            end
            if (evt.valid && evt.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    note_failure($sformatf("unexpected item kind=%0d slot=%0d last=%0d",
                                           evt.kind, evt.slot, evt.last));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (evt.kind !== want.kind || evt.slot !== want.slot ||
                        evt.last !== want.last)
                    begin
                        note_failure($sformatf(
                            "expected kind=%0d slot=%0d last=%0d, got kind=%0d slot=%0d last=%0d",
                            want.kind, want.slot, want.last, evt.kind, evt.slot, evt.last));
                    end
                end
            end
        end
        pending_count = expected_events.size();
    end

endmodule

### test/tb.sv
// Top of the timer table testbench: clock, reset, command stimulus and the final verdict.
module tb;
    import mstt_pkg::*;

    localparam int TIMER_SLOTS  = 16;
    localparam int RANDOM_ITEMS = 300;
    // Drain time at the end; it comfortably covers any late item, even from a full tick walk.
    localparam int DRAIN_CYCLES = 4 * TIMER_SLOTS;
    // Opcode that the block must swallow without any result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [NOW_W-1:0] TIME_MAX = {NOW_W{1'b1}};

    // Ways the result side paces its ready signal.
    typedef enum int {PACE_OPEN, PACE_COIN, PACE_QUARTER, PACE_MOSTLY} pace_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   burst_left;

    mstt_in_if  req_ch ();
    mstt_out_if rsp_ch ();

    multi_slot_software_timer_table #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // The checker watches both channels on its own; this module only drives them.
    mstt_checker #(
        .SLOTS(TIMER_SLOTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (req_ch),
        .evt          (rsp_ch),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Hard stop in case the block hangs or never delivers an expected item.
    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    // The result side switches between pacings at random: sometimes always
    // ready, sometimes random, sometimes on a fixed one-in-four beat.
    initial
    begin : result_pace
        pace_t mode;
        int    left;
        int    phase;
        rsp_ch.ready <= 1'b0;
        mode = PACE_OPEN;
        left = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = pace_t'($urandom_range(0, 3));
                left = $urandom_range(20, 80);
            end
            left--;
            phase++;
            case (mode)
                PACE_OPEN:    rsp_ch.ready <= 1'b1;
                PACE_COIN:    rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                PACE_QUARTER: rsp_ch.ready <= (phase % 4 == 0);
                default:      rsp_ch.ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Presents one command and holds it until the block takes it. Commands go out
    // in bursts; at the end of a burst valid may drop for a random pause.
    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_cmd(input logic [OP_W-1:0] op,
                            input logic [NOW_W-1:0] now,
                            input logic [PER_W-1:0] per,
                            input logic signed [RUNS_W-1:0] reps);
        int pause;
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= op;
        req_ch.now_seconds    <= now;
        req_ch.period_seconds <= per;
        req_ch.repeat_count   <= reps;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (pause > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        int                       i;
        int                       r;
        int                       pick;
        int unsigned              step;
        int                       durable_budget;
        int                       stuck_budget;
        logic [NOW_W-1:0]         wall;
        logic [OP_W-1:0]          op;
        logic [PER_W-1:0]         per;
        logic signed [RUNS_W-1:0] runs;

        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.opcode         <= OP_TICK;
        req_ch.now_seconds    <= '0;
        req_ch.period_seconds <= '0;
        req_ch.repeat_count   <= '0;
        burst_left = $urandom_range(1, 12);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first at time zero. An empty table still reports the end of a tick.
        send_cmd(OP_TICK, 32'd0, 20'd0, RUNS_NONE);
        // Zero-delay one-shot, endless repeat with the widest interval, a small count,
        // a count of zero, the largest count, and a one-shot whose count field is
        // all ones and must be ignored.
        send_cmd(OP_ADD_ONCE, 32'd0, 20'd0, RUNS_NONE);
        send_cmd(OP_ADD_REPEAT, 32'd0, 20'hFFFFF, RUNS_ENDLESS);
        send_cmd(OP_ADD_REPEAT, 32'd0, 20'd5, 17'sd2);
        send_cmd(OP_ADD_REPEAT, 32'd0, 20'd3, RUNS_NONE);
        send_cmd(OP_ADD_REPEAT, 32'd0, 20'd1, 17'sd65535);
        send_cmd(OP_ADD_ONCE, 32'd0, 20'hFFFFF, 17'h1FFFF);
        // Everything due at once: the zero-count slot asks for the sweep, which also
        // frees the expired one-shot.
        send_cmd(OP_TICK, 32'd0, 20'd0, RUNS_NONE);
        send_cmd(OP_UNUSED, 32'd3, 20'hFFFFF, 17'h1FFFF);
        // A tick where only a recurring slot fires, so no sweep happens.
        send_cmd(OP_TICK, 32'd4, 20'd0, RUNS_NONE);

        // Counts below minus one never fire and are never swept. They are added at the
        // largest time so they stay dormant until the clock reaches that value again.
        send_cmd(OP_ADD_REPEAT, TIME_MAX, 20'd1, -17'sd2);
        send_cmd(OP_ADD_REPEAT, TIME_MAX, 20'd0, 17'h10000);
        // Due times that clamp at the largest time, then fill the table and overflow it.
        send_cmd(OP_ADD_ONCE, 32'hFFFFFFF0, 20'hFFFFF, RUNS_NONE);
        for (i = 0; i < 9; i++)
        begin
            send_cmd(OP_ADD_ONCE, 32'hFFFFFFF0, PER_W'(2 * i), RUNS_NONE);
        end
        send_cmd(OP_ADD_REPEAT, 32'hFFFFFFF0, 20'd1, 17'sd1);
        // One second short of the clamped due times, then exactly on them.
        send_cmd(OP_TICK, 32'hFFFFFFFE, 20'd0, RUNS_NONE);
        send_cmd(OP_TICK, TIME_MAX, 20'd0, RUNS_NONE);

        // Random part. Time restarts low and mostly creeps forward, with rare long
        // jumps. Long-lived slots are rationed so the table keeps turning over, and
        // the never-firing kind only shows up near the end, since once present it
        // forces a sweep on every tick.
        wall = $urandom_range(0, 1000);
        durable_budget = 3;
        stuck_budget = 2;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            step = (pick < 3) ? $urandom_range(0, 32'h100000) : $urandom_range(0, 3);
            if (pick == 3)
            begin
                wall = $urandom();
            end
            else
            begin
                wall = (wall > TIME_MAX - step) ? TIME_MAX : wall + step;
            end

            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                op = OP_TICK;
            end
            else if (r < 65)
            begin
                op = OP_ADD_ONCE;
            end
            else if (r < 96)
            begin
                op = OP_ADD_REPEAT;
            end
            else
            begin
                op = OP_UNUSED;
            end

            per = ($urandom_range(0, 19) == 0) ? PER_W'($urandom()) : PER_W'($urandom_range(0, 6));
            runs = RUNS_W'($urandom());
            if (op == OP_ADD_REPEAT)
            begin
                r = $urandom_range(0, 19);
                if (r == 0 && durable_budget > 0)
                begin
                    durable_budget--;
                    runs = ($urandom_range(0, 1) == 0) ? RUNS_ENDLESS
                                                       : RUNS_W'($urandom_range(100, 65535));
                end
                else if (r <= 2 && stuck_budget > 0 && i > RANDOM_ITEMS * 4 / 5)
                begin
                    stuck_budget--;
                    runs = RUNS_W'(-int'($urandom_range(2, 65536)));
                end
                else
                begin
                    runs = RUNS_W'($urandom_range(0, 3));
                end
            end
            send_cmd(op, wall, per, runs);
        end
        req_ch.valid <= 1'b0;

        // Sample the checker away from the active edge so its update has settled.
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/mstt_pkg.sv
rtl/mstt_in_if.sv
rtl/mstt_out_if.sv
rtl/mstt_cell.sv
rtl/multi_slot_software_timer_table.sv
test/mstt_checker.sv
test/tb.sv
